// ===== hw/rtl/mbdi_pkg.sv =====
`timescale 1ns / 1ps

package mbdi_pkg;

    // number of debounced buttons
    localparam int BUTTONS = 10;

    // fixed field widths
    localparam int PIN_BITS   = 10;
    localparam int STAMP_W    = 32;
    localparam int DEB_W      = 16;
    localparam int IDX_W      = 4;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [IDX_W-1:0] FIRST_RESET    = 4'd8;
    localparam logic [IDX_W-1:0] SECOND_RESET   = 4'd9;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE_TIME    = 2'd0;
    localparam logic [1:0] REG_INTERLOCK_FIRST  = 2'd1;
    localparam logic [1:0] REG_INTERLOCK_SECOND = 2'd2;

    // per-button debounce phase
    typedef enum logic [1:0] {
        PHASE_IDLE        = 2'd0,
        PHASE_DEB_PRESS   = 2'd1,
        PHASE_PRESSED     = 2'd2,
        PHASE_DEB_RELEASE = 2'd3
    } phase_t;

    // input transaction payload
    typedef struct packed {
        logic [PIN_BITS-1:0] pin_levels;
        logic [STAMP_W-1:0]  now_time;
    } in_item_t;

    // output transaction payload
    typedef struct packed {
        logic [PIN_BITS-1:0] held_vector;
        logic                unlocked;
    } out_item_t;

endpackage

// ===== hw/rtl/multi_button_debounce_interlock_top.sv =====
`timescale 1ns / 1ps

// channel   signals                          direction  payload
// in        in_valid / in_ready / in_data    input      pin_levels, now_time
// out       out_valid / out_ready / out_data output     held_vector, unlocked
// cfg       psel penable pwrite paddr pwdata input      debounce_time, interlock pair
//
// one transaction per cycle unless a full output register stalls; once accepted,
// the result shows in the next cycle via the per-button 32-bit subtract and compare.
// in_ready stays high while the output register is empty or being drained.
// reset: every button idle, stamps zero, nothing confirmed, debounce 20,
// interlock buttons 8 and 9.

module multi_button_debounce_interlock_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mbdi_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mbdi_pkg::out_item_t                  out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mbdi_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mbdi_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mbdi_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    // configuration registers
    logic [mbdi_pkg::DEB_W-1:0] debounce_time_reg;
    logic [mbdi_pkg::IDX_W-1:0] interlock_first_reg;
    logic [mbdi_pkg::IDX_W-1:0] interlock_second_reg;

    // per-button state
    mbdi_pkg::phase_t             phase_reg    [mbdi_pkg::BUTTONS];
    mbdi_pkg::phase_t             phase_next   [mbdi_pkg::BUTTONS];
    logic [mbdi_pkg::STAMP_W-1:0] stamp_reg    [mbdi_pkg::BUTTONS];
    logic [mbdi_pkg::STAMP_W-1:0] stamp_next   [mbdi_pkg::BUTTONS];
    logic [mbdi_pkg::BUTTONS-1:0] confirmed_reg;
    logic [mbdi_pkg::BUTTONS-1:0] confirmed_next;
    logic [mbdi_pkg::BUTTONS-1:0] pressed;
    logic [mbdi_pkg::BUTTONS-1:0] stable;

    // output register
    logic                 out_valid_reg;
    mbdi_pkg::out_item_t  out_data_reg;
    mbdi_pkg::out_item_t  out_data_next;

    logic in_fire;
    logic cfg_write;
    logic first_held;
    logic second_held;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg    <= mbdi_pkg::DEBOUNCE_RESET;
            interlock_first_reg  <= mbdi_pkg::FIRST_RESET;
            interlock_second_reg <= mbdi_pkg::SECOND_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                mbdi_pkg::REG_DEBOUNCE_TIME:
                    debounce_time_reg <= pwdata[mbdi_pkg::DEB_W-1:0];
                mbdi_pkg::REG_INTERLOCK_FIRST:
                    interlock_first_reg <= pwdata[mbdi_pkg::IDX_W-1:0];
                mbdi_pkg::REG_INTERLOCK_SECOND:
                    interlock_second_reg <= pwdata[mbdi_pkg::IDX_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            mbdi_pkg::REG_DEBOUNCE_TIME:
                prdata[mbdi_pkg::DEB_W-1:0] = debounce_time_reg;
            mbdi_pkg::REG_INTERLOCK_FIRST:
                prdata[mbdi_pkg::IDX_W-1:0] = interlock_first_reg;
            mbdi_pkg::REG_INTERLOCK_SECOND:
                prdata[mbdi_pkg::IDX_W-1:0] = interlock_second_reg;
            default:
                prdata = '0;
        endcase
    end

    // raw level decode and elapsed-time compare per button
    genvar g;
    generate
        for (g = 0; g < mbdi_pkg::BUTTONS; g++)
        begin : g_btn
            if (g < mbdi_pkg::PIN_BITS)
            begin : g_pin
                assign pressed[g] = !in_data.pin_levels[g];
            end
            else
            begin : g_nopin
                assign pressed[g] = 1'b0;
            end
            assign stable[g] = (in_data.now_time - stamp_reg[g])
                               >= {{(mbdi_pkg::STAMP_W-mbdi_pkg::DEB_W){1'b0}},
                                   debounce_time_reg};
        end
    endgenerate

    // debounce machines, all buttons side by side
    always_comb
    begin
        for (int i = 0; i < mbdi_pkg::BUTTONS; i++)
        begin
            phase_next[i]     = phase_reg[i];
            stamp_next[i]     = stamp_reg[i];
            confirmed_next[i] = confirmed_reg[i];
            case (phase_reg[i])
                mbdi_pkg::PHASE_IDLE:
                begin
                    if (pressed[i])
                    begin
                        phase_next[i] = mbdi_pkg::PHASE_DEB_PRESS;
                        stamp_next[i] = in_data.now_time;
                    end
                end
                mbdi_pkg::PHASE_DEB_PRESS:
                begin
                    if (!pressed[i])
                        phase_next[i] = mbdi_pkg::PHASE_IDLE;
                    else if (stable[i])
                    begin
                        phase_next[i]     = mbdi_pkg::PHASE_PRESSED;
                        confirmed_next[i] = 1'b1;
                    end
                end
                mbdi_pkg::PHASE_PRESSED:
                begin
                    if (!pressed[i])
                    begin
                        phase_next[i] = mbdi_pkg::PHASE_DEB_RELEASE;
                        stamp_next[i] = in_data.now_time;
                    end
                end
                mbdi_pkg::PHASE_DEB_RELEASE:
                begin
                    if (pressed[i])
                        phase_next[i] = mbdi_pkg::PHASE_PRESSED;
                    else if (stable[i])
                    begin
                        phase_next[i]     = mbdi_pkg::PHASE_IDLE;
                        confirmed_next[i] = 1'b0;
                    end
                end
                default:
                    phase_next[i] = phase_reg[i];
            endcase
        end
    end

    // interlock lookup; an index past the last button matches nothing
    always_comb
    begin
        first_held  = 1'b0;
        second_held = 1'b0;
        for (int i = 0; i < mbdi_pkg::BUTTONS; i++)
        begin
            if (int'(interlock_first_reg) == i && confirmed_next[i])
                first_held = 1'b1;
            if (int'(interlock_second_reg) == i && confirmed_next[i])
                second_held = 1'b1;
        end
    end

    // result assembly
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < mbdi_pkg::BUTTONS; i++)
        begin
            if (i < mbdi_pkg::PIN_BITS)
                out_data_next.held_vector[i] = confirmed_next[i];
        end
        out_data_next.unlocked = first_held && second_held;
    end

    // button state, updated once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg <= '0;
            for (int i = 0; i < mbdi_pkg::BUTTONS; i++)
            begin
                phase_reg[i] <= mbdi_pkg::PHASE_IDLE;
                stamp_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            confirmed_reg <= confirmed_next;
            for (int i = 0; i < mbdi_pkg::BUTTONS; i++)
            begin
                phase_reg[i] <= phase_next[i];
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    // an accepted transaction always leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted transaction produced no result");

    // button state moves only on an accepted transaction
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(confirmed_reg))
        else $error("confirmed state changed without a transaction");

    // confirmed exactly in the pressed and release-debounce phases
    generate
        for (g = 0; g < mbdi_pkg::BUTTONS; g++)
        begin : g_chk
            a_confirm_phase: assert property (@(posedge clk) disable iff (!rst_n)
                confirmed_reg[g] == (phase_reg[g] == mbdi_pkg::PHASE_PRESSED ||
                                     phase_reg[g] == mbdi_pkg::PHASE_DEB_RELEASE))
                else $error("confirmed bit disagrees with debounce phase");
        end
    endgenerate

endmodule

// ===== tb/sv/debounce_checker.sv =====
`timescale 1ns / 1ps

module debounce_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  mbdi_pkg::in_item_t                   in_data,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  mbdi_pkg::out_item_t                  out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mbdi_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mbdi_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic                                 pready,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    import mbdi_pkg::*;

    // shadow copy of the configuration registers
    logic [DEB_W-1:0] deb_ms;
    logic [IDX_W-1:0] lock_a;
    logic [IDX_W-1:0] lock_b;

    // shadow copy of the per-button debounce state
    phase_t             btn_phase [BUTTONS];
    logic [STAMP_W-1:0] btn_stamp [BUTTONS];
    logic [BUTTONS-1:0] btn_held;

    // results still owed by the block, oldest first
    out_item_t expected_held [$];

    // advance every button by one tick and form the result it produces
    function automatic out_item_t debounce_tick(input in_item_t tick);
        out_item_t          res;
        logic               pressed;
        logic               stable;
        logic [STAMP_W-1:0] elapsed;
        res = '0;
        for (int i = 0; i < BUTTONS; i++)
        begin
            // buttons with no pin bit read as released
            pressed = (i < PIN_BITS) ? ~tick.pin_levels[i] : 1'b0;
            elapsed = tick.now_time - btn_stamp[i];
            stable  = elapsed >= STAMP_W'(deb_ms);
            case (btn_phase[i])
                PHASE_IDLE:
                begin
                    if (pressed)
                    begin
                        btn_phase[i] = PHASE_DEB_PRESS;
                        btn_stamp[i] = tick.now_time;
                    end
                end
                PHASE_DEB_PRESS:
                begin
                    if (!pressed)
                        btn_phase[i] = PHASE_IDLE;
                    else if (stable)
                    begin
                        btn_phase[i] = PHASE_PRESSED;
                        btn_held[i]  = 1'b1;
                    end
                end
                PHASE_PRESSED:
                begin
                    if (!pressed)
                    begin
                        btn_phase[i] = PHASE_DEB_RELEASE;
                        btn_stamp[i] = tick.now_time;
                    end
                end
                default:
                begin
                    if (pressed)
                        btn_phase[i] = PHASE_PRESSED;
                    else if (stable)
                    begin
                        btn_phase[i] = PHASE_IDLE;
                        btn_held[i]  = 1'b0;
                    end
                end
            endcase
            if (i < PIN_BITS)
                res.held_vector[i] = btn_held[i];
        end
        // an index past the last button counts as not held
        res.unlocked = (lock_a < BUTTONS) && (lock_b < BUTTONS)
                       && btn_held[lock_a] && btn_held[lock_b];
        return res;
    endfunction

    // count a failure, print only the first few
    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // watch all three ports
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            deb_ms  = DEBOUNCE_RESET;
            lock_a  = FIRST_RESET;
            lock_b  = SECOND_RESET;
            for (int i = 0; i < BUTTONS; i++)
            begin
                btn_phase[i] = PHASE_IDLE;
                btn_stamp[i] = '0;
            end
            btn_held   = '0;
            expected_held.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            // output transaction against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_held.size() == 0)
                    note_mismatch($sformatf("result %0h/%0b with nothing expected",
                                            out_data.held_vector, out_data.unlocked));
                else
                begin
                    want = expected_held.pop_front();
                    checked++;
                    if (out_data.held_vector !== want.held_vector)
                        note_mismatch($sformatf("held_vector expected %0h got %0h",
                                                want.held_vector, out_data.held_vector));
                    if (out_data.unlocked !== want.unlocked)
                        note_mismatch($sformatf("unlocked expected %0b got %0b",
                                                want.unlocked, out_data.unlocked));
                end
            end
            // input transaction: predict its result
            if (in_valid && in_ready)
                expected_held.push_back(debounce_tick(in_data));
            // register write; unused indexes are ignored
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_DEBOUNCE_TIME:    deb_ms = pwdata[DEB_W-1:0];
                    REG_INTERLOCK_FIRST:  lock_a = pwdata[IDX_W-1:0];
                    REG_INTERLOCK_SECOND: lock_b = pwdata[IDX_W-1:0];
                    default:              ;
                endcase
            end
            pending = expected_held.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import mbdi_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 5000;
    localparam int         LONG_HOLD       = 60;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         ITEMS_PER_PHASE = 105;
    localparam logic [1:0] REG_UNUSED      = 2'd3;
    localparam logic [PIN_BITS-1:0] ALL_UP = '1;

    // who stalls: slow sink first, then slow source, then full rate
    typedef enum logic [1:0] {
        MODE_SLOW_SINK,
        MODE_SLOW_SOURCE,
        MODE_FULL_RATE
    } idle_mode_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_data  = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int         fail_count;
    int         pending;
    int         checked;
    int         ticks_sent  = 0;
    int         writes_done = 0;
    int         quiet       = 0;
    idle_mode_t idle_mode   = MODE_FULL_RATE;
    logic       long_hold_req  = 1'b0;
    logic       long_hold_seen = 1'b0;
    int         long_hold_left = 0;

    always #5 clk = ~clk;

    multi_button_debounce_interlock_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    debounce_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // result side: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (long_hold_left != 0)
        begin
            out_ready      <= 1'b0;
            long_hold_left <= long_hold_left - 1;
        end
        else if (long_hold_req != long_hold_seen)
        begin
            long_hold_seen <= long_hold_req;
            long_hold_left <= LONG_HOLD;
            out_ready      <= 1'b0;
        end
        else
        begin
            case (idle_mode)
                MODE_SLOW_SINK:   out_ready <= $urandom_range(0, 99) >= 68;
                MODE_SLOW_SOURCE: out_ready <= $urandom_range(0, 99) >= 18;
                default:          out_ready <= 1'b1;
            endcase
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet <= 0;
            else if (quiet + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // offer one tick, holding it until accepted
    task automatic send_tick(input logic [PIN_BITS-1:0] pins,
                             input logic [STAMP_W-1:0] stamp);
        in_item_t tick;
        int       gap_pct;
        tick.pin_levels = pins;
        tick.now_time   = stamp;
        case (idle_mode)
            MODE_SLOW_SINK:   gap_pct = 18;
            MODE_SLOW_SOURCE: gap_pct = 68;
            default:          gap_pct = 0;
        endcase
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        ticks_sent++;
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // two-phase register write, setup then access, after which the bus goes idle
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    initial
    begin
        logic [PIN_BITS-1:0] level;
        logic [PIN_BITS-1:0] pins;
        logic [STAMP_W-1:0]  now;
        logic [APB_DATA_W-1:0] deb_value;
        int                  pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full press, bounces on both edges, release
        send_tick(ALL_UP, 32'd0);
        send_tick('0, 32'd100);
        send_tick('0, 32'd110);
        send_tick('0, 32'd120);
        send_tick(10'h3F7, 32'd121);
        send_tick('0, 32'd122);
        send_tick(ALL_UP, 32'd130);
        send_tick('0, 32'd131);
        send_tick(ALL_UP, 32'd140);
        send_tick(ALL_UP, 32'd159);
        send_tick(ALL_UP, 32'd160);
        // debounce window across the timestamp wrap
        send_tick(10'h155, 32'hFFFF_FFF0);
        send_tick(10'h155, 32'h0000_0003);
        send_tick(10'h155, 32'h0000_0004);
        send_tick(ALL_UP, 32'hFFFF_FFFF);
        send_tick(ALL_UP, 32'h0000_0013);
        settle();

        // zero debounce, one interlock index past the last button
        apb_write(REG_DEBOUNCE_TIME, 32'd0);
        apb_write(REG_INTERLOCK_FIRST, 32'd0);
        apb_write(REG_INTERLOCK_SECOND, 32'd15);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_tick(10'h3FE, 32'd500);
        send_tick(10'h3FE, 32'd500);
        send_tick(ALL_UP, 32'd500);
        send_tick(ALL_UP, 32'd500);
        settle();

        // longest debounce, both interlock slots on one button
        apb_write(REG_DEBOUNCE_TIME, 32'h0000_FFFF);
        apb_write(REG_INTERLOCK_FIRST, 32'd1);
        apb_write(REG_INTERLOCK_SECOND, 32'd1);
        send_tick(10'h3FC, 32'd1000);
        send_tick(10'h3FC, 32'd1000 + 32'd65534);
        send_tick(10'h3FC, 32'd1000 + 32'd65535);
        send_tick(ALL_UP, 32'd1000 + 32'd65536);

        // random button traffic, one register setting per phase
        level = ALL_UP;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p / 2)
                0:       idle_mode <= MODE_SLOW_SINK;
                1:       idle_mode <= MODE_SLOW_SOURCE;
                default: idle_mode <= MODE_FULL_RATE;
            endcase
            case (p)
                0:       deb_value = 32'd3;
                1:       deb_value = 32'd0;
                2:       deb_value = 32'h0000_FFFF;
                3:       deb_value = $urandom_range(1, 8);
                4:       deb_value = 32'd1;
                default: deb_value = ($urandom & 32'hFFFF_0000) | $urandom_range(2, 12);
            endcase
            apb_write(REG_DEBOUNCE_TIME, deb_value);
            apb_write(REG_INTERLOCK_FIRST, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 15) : $urandom_range(0, 9));
            apb_write(REG_INTERLOCK_SECOND, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 15) : $urandom_range(0, 9));
            now = (p == 4) ? 32'hFFFF_FF80 : $urandom;
            // long result-side stall while ticks keep coming
            if (p == 0)
                long_hold_req <= ~long_hold_req;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // buttons mostly hold their level for a while
                for (int b = 0; b < PIN_BITS; b++)
                    if ($urandom_range(0, 99) < 6)
                        level[b] = ~level[b];
                pins = level;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    pins[$urandom_range(0, PIN_BITS - 1)] ^= 1'b1;
                else if (pick < 13)
                    pins ^= PIN_BITS'($urandom);
                // mostly one ms per tick, sometimes stalled or jumping
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    now = now + 32'd1;
                else if (pick >= 90 && pick < 97)
                    now = now + $urandom_range(2, 40);
                else if (pick >= 97)
                    now = now + $urandom;
                send_tick(pins, now);
            end
        end
        settle();

        $display("run covered %0d ticks and %0d register writes: debounce 0 to 65535,",
                 ticks_sent, writes_done);
        $display("stamp wrap, bounces, unused interlock indexes; %0d results compared",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
